[hw/rtl/sigrrip_pkg.sv]
package sigrrip_pkg;

  // Cache geometry and predictor size. SETS and SIG_ENTRIES are powers of two.
  localparam int SETS        = 2048;
  localparam int WAYS        = 16;
  localparam int SIG_ENTRIES = 1024;
  localparam int AGE_BITS    = 2;

  // Fixed field widths of the channel words.
  localparam int SET_IDX_W = 11;
  localparam int HIT_WAY_W = 4;
  localparam int PC_W      = 22;
  localparam int CHOSEN_W  = 4;
  localparam int INS_AGE_W = 2;

  localparam int SET_W = $clog2(SETS);
  localparam int WAY_W = $clog2(WAYS);
  localparam int SIG_W = $clog2(SIG_ENTRIES);

  // The clearing pass sweeps both memories together.
  localparam int CLR_N = (SETS > SIG_ENTRIES) ? SETS : SIG_ENTRIES;
  localparam int CLR_W = $clog2(CLR_N);

  typedef logic [AGE_BITS-1:0] age_t;
  typedef logic [SIG_W-1:0]    sig_t;
  typedef logic [WAY_W-1:0]    way_t;
  typedef logic [SET_W-1:0]    set_t;
  typedef logic [1:0]          ctr_t;

  localparam age_t MAX_AGE = age_t'((1 << AGE_BITS) - 1);
  localparam ctr_t CTR_TOP = 2'd3;
  localparam ctr_t CTR_MID = 2'd2;

  typedef struct packed {
    age_t age;
    logic valid;
    logic reused;
    sig_t sig;
  } line_t;

  typedef line_t [WAYS-1:0] set_word_t;

  typedef struct packed {
    logic [SET_IDX_W-1:0] set_index;
    logic                 is_hit;
    logic [HIT_WAY_W-1:0] hit_way;
    logic [PC_W-1:0]      pc;
  } req_t;

  typedef struct packed {
    logic [CHOSEN_W-1:0]  chosen_way;
    logic                 evicted_valid;
    logic [INS_AGE_W-1:0] insert_age;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_we;
    logic capture;
    logic scan_en;
    logic pick_en;
    logic hit_wr;
    logic fill_wr;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic is_hit;
  } sts_t;

endpackage

[hw/rtl/sigrrip_req_if.sv]
interface sigrrip_req_if
  import sigrrip_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [SET_IDX_W-1:0] set_index;
  logic                 is_hit;
  logic [HIT_WAY_W-1:0] hit_way;
  logic [PC_W-1:0]      pc;

  modport source (output valid, output set_index, output is_hit, output hit_way,
                  output pc, input ready);
  modport sink (input valid, input set_index, input is_hit, input hit_way,
                input pc, output ready);
endinterface

[hw/rtl/sigrrip_rsp_if.sv]
interface sigrrip_rsp_if
  import sigrrip_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CHOSEN_W-1:0]  chosen_way;
  logic                 evicted_valid;
  logic [INS_AGE_W-1:0] insert_age;

  modport source (output valid, output chosen_way, output evicted_valid,
                  output insert_age, input ready);
  modport sink (input valid, input chosen_way, input evicted_valid,
                input insert_age, output ready);
endinterface

[hw/rtl/signature_rrip_replacement_unit.sv]
// Signature-based RRIP replacement unit. Each input word is one cache access
// (set index, hit flag, hit way, requesting PC) and produces exactly one result
// word: the way that was touched or filled, whether a valid line was evicted,
// and the age written to that way. A hit goes from acceptance through the scan
// state back to idle; a miss goes through the scan, pick and fill states, as
// the set's metadata word is read, scanned for a free or oldest way, aged if
// none is free, and written back with a read-modify-write of the reuse
// predictor. A new access is taken only back in idle. After reset the unit
// runs a clearing pass over max(SETS, SIG_ENTRIES) entries, 2048 with the
// default sizes, during which no access word is accepted. A finished result
// waits in an output register, so the next access is taken while it waits.

module signature_rrip_replacement_unit
  import sigrrip_pkg::*;
(
  input logic           clk,
  input logic           rst_n,
  sigrrip_req_if.sink   in_item,
  sigrrip_rsp_if.source out_item
);

  cmd_t cmd;
  sts_t sts;
  req_t req;
  rsp_t rsp;

  // Gather the access word into one bundle for the datapath.
  assign req.set_index = in_item.set_index;
  assign req.is_hit    = in_item.is_hit;
  assign req.hit_way   = in_item.hit_way;
  assign req.pc        = in_item.pc;

  // The result payload is held in the datapath's output register.
  assign out_item.chosen_way    = rsp.chosen_way;
  assign out_item.evicted_valid = rsp.evicted_valid;
  assign out_item.insert_age    = rsp.insert_age;

  sigrrip_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_item.valid),
    .in_ready  (in_item.ready),
    .out_valid (out_item.valid),
    .out_ready (out_item.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sigrrip_dp u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .cmd   (cmd),
    .sts   (sts),
    .rsp   (rsp)
  );

endmodule

[hw/rtl/sigrrip_ctrl.sv]
module sigrrip_ctrl
  import sigrrip_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_FILL
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   finish;

  // The result register can take a new word when empty or being drained.
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd         = '0;
    cmd.clr_we  = (state_r == ST_CLEAR);
    cmd.capture = (state_r == ST_IDLE) && in_valid;
    cmd.scan_en = (state_r == ST_SCAN) && !sts.is_hit;
    cmd.pick_en = (state_r == ST_PICK);
    cmd.hit_wr  = (state_r == ST_SCAN) && sts.is_hit && out_free;
    cmd.fill_wr = (state_r == ST_FILL) && out_free;
  end

  assign finish = cmd.hit_wr || cmd.fill_wr;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (!sts.is_hit) state_nxt = ST_PICK;
        else if (out_free) state_nxt = ST_IDLE;
      end
      ST_PICK: begin
        state_nxt = ST_FILL;
      end
      ST_FILL: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (finish) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hw/rtl/sigrrip_dp.sv]
module sigrrip_dp
  import sigrrip_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  req_t req,
  input  cmd_t cmd,
  output sts_t sts,
  output rsp_t rsp
);

  localparam line_t     CLR_LINE = '{age: MAX_AGE, valid: 1'b0, reused: 1'b0, sig: '0};
  localparam set_word_t CLR_WORD = {WAYS{CLR_LINE}};

  // Set metadata memory and the signature reuse counters.
  set_word_t set_mem [SETS];
  ctr_t      pred_mem [SIG_ENTRIES];

  logic [CLR_W-1:0] clr_idx_r;
  set_t             set_r;
  logic             hit_r;
  logic [HIT_WAY_W-1:0] hway_r;
  sig_t             sig_new_r;
  set_word_t        set_rd_r;
  logic             inv_found_r;
  way_t             inv_way_r;
  age_t             oldest_r;
  way_t             victim_r;
  set_word_t        work_r;
  logic             evicted_r;
  logic             reused_r;
  sig_t             old_sig_r;
  ctr_t             pred_old_r;
  ctr_t             pred_new_r;
  rsp_t             rsp_r;

  function automatic sig_t pc_signature(logic [PC_W-1:0] pc);
    logic [PC_W-1:0] mix;
    mix = (pc >> 2) ^ (pc >> 12);
    return sig_t'(mix);
  endfunction

  assign sts.clr_last = (clr_idx_r == CLR_W'(CLR_N - 1));
  assign sts.is_hit   = hit_r;
  assign rsp          = rsp_r;

  // Clearing pass counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clr_we) begin
      clr_idx_r <= clr_idx_r + CLR_W'(1);
    end
  end

  // Captured request.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      set_r     <= set_t'(req.set_index);
      hit_r     <= req.is_hit;
      hway_r    <= req.hit_way;
      sig_new_r <= pc_signature(req.pc);
    end
  end

  // Scan of the set word: first invalid way and the oldest age present.
  logic         inv_found_c;
  way_t         inv_way_c;
  age_t         oldest_c;
  logic [(1 << AGE_BITS)-1:0] age_seen_c;

  always_comb begin
    inv_found_c = 1'b0;
    inv_way_c   = '0;
    age_seen_c  = '0;
    oldest_c    = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!set_rd_r[w].valid) begin
        inv_found_c = 1'b1;
        inv_way_c   = WAY_W'(w);
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      age_seen_c[set_rd_r[w].age] = 1'b1;
    end
    for (int v = 0; v < (1 << AGE_BITS); v++) begin
      if (age_seen_c[v]) oldest_c = AGE_BITS'(v);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_en) begin
      inv_found_r <= inv_found_c;
      inv_way_r   <= inv_way_c;
      oldest_r    <= oldest_c;
    end
  end

  // Victim pick and aging of the set.
  way_t      victim_c;
  set_word_t aged_c;
  age_t      bump_c;

  always_comb begin
    bump_c   = MAX_AGE - oldest_r;
    aged_c   = set_rd_r;
    victim_c = inv_way_r;
    if (!inv_found_r) begin
      for (int w = WAYS - 1; w >= 0; w--) begin
        if (set_rd_r[w].age == oldest_r) victim_c = WAY_W'(w);
      end
      for (int w = 0; w < WAYS; w++) begin
        aged_c[w].age = set_rd_r[w].age + bump_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick_en) begin
      victim_r  <= victim_c;
      work_r    <= aged_c;
      evicted_r <= set_rd_r[victim_c].valid;
      reused_r  <= set_rd_r[victim_c].reused;
      old_sig_r <= set_rd_r[victim_c].sig;
    end
  end

  // Counter update and insertion age.
  ctr_t      upd_c;
  ctr_t      cnt_c;
  age_t      ins_age_c;
  set_word_t fill_c;
  set_word_t hit_c;
  way_t      hway_idx_c;
  logic      hway_ok_c;

  always_comb begin
    if (reused_r) begin
      upd_c = (pred_old_r == CTR_TOP) ? pred_old_r : pred_old_r + ctr_t'(1);
    end else begin
      upd_c = (pred_old_r == 2'd0) ? pred_old_r : pred_old_r - ctr_t'(1);
    end
    // The new signature may be the one just trained.
    cnt_c = (evicted_r && (old_sig_r == sig_new_r)) ? upd_c : pred_new_r;
    case (cnt_c)
      CTR_TOP: ins_age_c = '0;
      CTR_MID: ins_age_c = MAX_AGE - age_t'(1);
      default: ins_age_c = MAX_AGE;
    endcase
    fill_c                  = work_r;
    fill_c[victim_r].age    = ins_age_c;
    fill_c[victim_r].valid  = 1'b1;
    fill_c[victim_r].reused = 1'b0;
    fill_c[victim_r].sig    = sig_new_r;

    hway_ok_c  = (int'(hway_r) < WAYS);
    hway_idx_c = WAY_W'(hway_r);
    hit_c      = set_rd_r;
    hit_c[hway_idx_c].age    = '0;
    hit_c[hway_idx_c].reused = 1'b1;
  end

  // Set memory port selection.
  logic      set_we_c;
  set_t      set_waddr_c;
  set_word_t set_wdata_c;

  always_comb begin
    set_we_c    = 1'b0;
    set_waddr_c = set_r;
    set_wdata_c = fill_c;
    if (cmd.clr_we) begin
      set_we_c    = ((CLR_W + 1)'(clr_idx_r) < (CLR_W + 1)'(SETS));
      set_waddr_c = clr_idx_r[SET_W-1:0];
      set_wdata_c = CLR_WORD;
    end else if (cmd.hit_wr) begin
      set_we_c    = hway_ok_c;
      set_wdata_c = hit_c;
    end else if (cmd.fill_wr) begin
      set_we_c    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (set_we_c) set_mem[set_waddr_c] <= set_wdata_c;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) set_rd_r <= set_mem[set_t'(req.set_index)];
  end

  // Predictor memory port selection.
  logic pred_we_c;
  sig_t pred_waddr_c;
  ctr_t pred_wdata_c;

  always_comb begin
    pred_we_c    = 1'b0;
    pred_waddr_c = old_sig_r;
    pred_wdata_c = upd_c;
    if (cmd.clr_we) begin
      pred_we_c    = ((CLR_W + 1)'(clr_idx_r) < (CLR_W + 1)'(SIG_ENTRIES));
      pred_waddr_c = clr_idx_r[SIG_W-1:0];
      pred_wdata_c = CTR_MID;
    end else if (cmd.fill_wr) begin
      pred_we_c    = evicted_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pred_we_c) pred_mem[pred_waddr_c] <= pred_wdata_c;
  end

  always_ff @(posedge clk) begin
    if (cmd.pick_en) begin
      pred_old_r <= pred_mem[set_rd_r[victim_c].sig];
      pred_new_r <= pred_mem[sig_new_r];
    end
  end

  // Result word.
  always_ff @(posedge clk) begin
    if (cmd.hit_wr) begin
      rsp_r.chosen_way    <= CHOSEN_W'(hway_r);
      rsp_r.evicted_valid <= 1'b0;
      rsp_r.insert_age    <= '0;
    end else if (cmd.fill_wr) begin
      rsp_r.chosen_way    <= CHOSEN_W'(victim_r);
      rsp_r.evicted_valid <= evicted_r;
      rsp_r.insert_age    <= INS_AGE_W'(ins_age_c);
    end
  end

endmodule
